// ----- src/nrc_pkg.sv -----
// ----------------------------------------------------------------------------
// nrc_pkg: shared types and constants of the nonce replay cache
// Entry layout, store access request, compare result and cache geometry.
// ----------------------------------------------------------------------------
package nrc_pkg;

  localparam int CACHE_ENTRIES = 32;
  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(CACHE_ENTRIES - 1);

  localparam logic [7:0]  CLEARED_DEVICE = 8'hFF;
  localparam logic [31:0] DEFAULT_WINDOW = 32'd10000;

  typedef struct packed {
    logic [7:0]  device;
    logic [31:0] nonce;
    logic [31:0] stamp;
  } entry_t;

  localparam entry_t CLEARED_ENTRY = '{device: CLEARED_DEVICE, nonce: 32'd0, stamp: 32'd0};

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic match;
    logic expire;
  } cmp_t;

endpackage

// ----- src/nrc_store.sv -----
// ----------------------------------------------------------------------------
// nrc_store: cache entry memory
// One write and one registered read port; per-entry valid bits make an
// entry that was never written since reset read as all zeros.
// ----------------------------------------------------------------------------
module nrc_store (
  input  logic              clk,
  input  logic              rst,
  input  nrc_pkg::mem_req_t req,
  output nrc_pkg::entry_t   rd_data
);

  nrc_pkg::entry_t mem [nrc_pkg::CACHE_ENTRIES];
  logic [nrc_pkg::CACHE_ENTRIES-1:0] valid;
  nrc_pkg::entry_t rd_raw;
  logic            rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_raw <= mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
      rd_valid <= valid[req.rd_addr];
    end
  end

  assign rd_data = rd_valid ? rd_raw : '0;

endmodule

// ----- src/nrc_cmp.sv -----
// ----------------------------------------------------------------------------
// nrc_cmp: shared entry compare unit
// Checks one stored entry against the current item for a device and nonce
// match, and for an age beyond the expiry window.
// ----------------------------------------------------------------------------
module nrc_cmp (
  input  nrc_pkg::entry_t entry,
  input  nrc_pkg::entry_t item,
  input  logic [31:0]     window,
  output nrc_pkg::cmp_t   result
);

  logic [31:0] age;

  // Age wraps modulo 2^32, so a stamp ahead of now looks very old.
  assign age           = item.stamp - entry.stamp;
  assign result.match  = (entry.device == item.device) && (entry.nonce == item.nonce);
  assign result.expire = age > window;

endmodule

// ----- src/nrc_ctrl.sv -----
// ----------------------------------------------------------------------------
// nrc_ctrl: item sequencer
// Walks the store for a replay match, inserts a fresh item at the
// round-robin pointer, walks it again to clear expired entries, and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module nrc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       nonce_value,
  input  logic [7:0]        device_id,
  input  logic [31:0]       now_ms,
  input  nrc_pkg::cmp_t     cmp,
  output nrc_pkg::entry_t   item,
  output nrc_pkg::mem_req_t mem_req,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              accepted
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MATCH = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_EXPST = 3'd3;
  localparam logic [2:0] S_EXP   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]               state;
  logic [2:0]               state_next;
  logic [nrc_pkg::IDX_W-1:0] cnt;
  logic [nrc_pkg::IDX_W-1:0] cnt_next;
  logic [nrc_pkg::IDX_W-1:0] ptr;
  logic [nrc_pkg::IDX_W-1:0] ptr_next;
  logic                     res;
  logic                     res_next;
  logic                     out_valid_next;
  logic                     in_fire;
  logic                     out_free;
  logic [nrc_pkg::IDX_W-1:0] cnt_inc;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign cnt_inc  = (cnt == nrc_pkg::LAST_INDEX) ? '0 : cnt + 1'b1;

  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    ptr_next         = ptr;
    res_next         = res;
    out_valid_next   = out_valid && out_stall;
    mem_req.wr_en    = 1'b0;
    mem_req.wr_addr  = ptr;
    mem_req.wr_data  = item;
    mem_req.rd_addr  = '0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cnt_next   = '0;
          state_next = S_MATCH;
        end
      end
      S_MATCH: begin
        mem_req.rd_addr = cnt_inc;
        if (cmp.match) begin
          res_next   = 1'b0;
          state_next = S_DONE;
        end else if (cnt == nrc_pkg::LAST_INDEX) begin
          state_next = S_WRITE;
        end else begin
          cnt_next = cnt_inc;
        end
      end
      S_WRITE: begin
        mem_req.wr_en = 1'b1;
        ptr_next      = (ptr == nrc_pkg::LAST_INDEX) ? '0 : ptr + 1'b1;
        state_next    = S_EXPST;
      end
      S_EXPST: begin
        cnt_next   = '0;
        state_next = S_EXP;
      end
      S_EXP: begin
        mem_req.rd_addr = cnt_inc;
        mem_req.wr_en   = cmp.expire;
        mem_req.wr_addr = cnt;
        mem_req.wr_data = nrc_pkg::CLEARED_ENTRY;
        if (cnt == nrc_pkg::LAST_INDEX) begin
          res_next   = 1'b1;
          state_next = S_DONE;
        end else begin
          cnt_next = cnt_inc;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ptr       <= ptr_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt <= cnt_next;
    res <= res_next;
    if (in_fire) begin
      item.device <= device_id;
      item.nonce  <= nonce_value;
      item.stamp  <= now_ms;
    end
    if ((state == S_DONE) && out_free) begin
      accepted <= res;
    end
  end

endmodule

// ----- src/nonce_replay_cache.sv -----
// ----------------------------------------------------------------------------
// nonce_replay_cache: replay protection cache of recent nonces per device
// Rejects an item whose device and nonce are already cached; otherwise
// stores it round robin and clears entries older than the expiry window.
// ----------------------------------------------------------------------------
// Sequence: a replay ends the match walk at its first matching entry and answers; a
// fresh item runs the full match walk, the insert, a walk setup step and the full
// expiry walk before it answers. The answer waits while out_stall holds the output.
// Flow: one item at a time; the next item can be taken in the cycle the answer shows.
// The two walks run over the single read port of the entry memory, one entry per cycle each.
// Reset (synchronous, rst high): store reads as all zeros, pointer zero, window 10000 ms.
// ----------------------------------------------------------------------------
module nonce_replay_cache (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] nonce_value,
  input  logic [7:0]  device_id,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  // The expiry window register. The user must write it only while the block is idle,
  // which the block itself does not enforce, so the compare unit can read it directly.
  logic [31:0] expiry_window_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      expiry_window_ms <= nrc_pkg::DEFAULT_WINDOW;
    end else if (cfg_wr_en) begin
      expiry_window_ms <= cfg_wr_data;
    end
  end

  nrc_pkg::mem_req_t mem_req;
  nrc_pkg::entry_t   rd_data;
  nrc_pkg::entry_t   item;
  nrc_pkg::cmp_t     cmp;

  // Entry memory: the sequencer reads one entry per cycle, and the data
  // comes back registered in the following cycle.
  nrc_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // The one compare unit serves both walks: the match walk looks at the
  // match flag and the expiry walk at the age flag.
  nrc_cmp u_cmp (
    .entry  (rd_data),
    .item   (item),
    .window (expiry_window_ms),
    .result (cmp)
  );

  // Sequencer and output register. The insert happens in its own cycle
  // between the walks so the expiry walk sees the new entry.
  nrc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .nonce_value (nonce_value),
    .device_id   (device_id),
    .now_ms      (now_ms),
    .cmp         (cmp),
    .item        (item),
    .mem_req     (mem_req),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .accepted    (accepted)
  );

  // An item taken at the input keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accepted item");

  // The store is never written while the block waits for an item.
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !mem_req.wr_en)
    else $error("store written while idle");

  // Writes stay inside the cache.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |-> mem_req.wr_addr <= nrc_pkg::LAST_INDEX)
    else $error("store write beyond the last entry");

endmodule
